[rtl/amc_pkg.sv]
// amc_pkg: shared types and constants of the accelerometer motion classifier
// used by amc_isqrt, accel_motion_classifier_unit and the bench; depends on nothing else

package amc_pkg;

  localparam int AXIS_W   = 16;
  localparam int MAG_W    = 16;
  localparam int CFG_W    = 16;
  localparam int CLASS_W  = 2;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int OP_COUNT = 5;

  localparam int WINDOW_DEPTH_DEF = 16;

  localparam logic [MAG_W-1:0] MAG_MAX = 16'd56755;

  localparam logic [CFG_W-1:0] SHAKE_RST   = 16'd2500;
  localparam logic [CFG_W-1:0] CARRIED_RST = 16'd800;
  localparam logic [CFG_W-1:0] TRANSIT_RST = 16'd200;
  localparam logic [CFG_W-1:0] ONE_G_RST   = 16'd16384;

  typedef enum logic [1:0] {
    REG_SHAKE   = 2'd0,
    REG_CARRIED = 2'd1,
    REG_TRANSIT = 2'd2,
    REG_ONE_G   = 2'd3
  } cfg_reg_e;

  typedef enum logic [CLASS_W-1:0] {
    CLASS_STATIONARY = 2'd0,
    CLASS_TRANSIT    = 2'd1,
    CLASS_CARRIED    = 2'd2,
    CLASS_SHAKEN     = 2'd3
  } motion_class_e;

  typedef enum logic [1:0] {
    TAG_ACC = 2'd0,
    TAG_CSQ = 2'd1,
    TAG_TSQ = 2'd2
  } op_tag_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_SQUARE = 3'd1,
    ST_ROOT   = 3'd2,
    ST_UPDATE = 3'd3,
    ST_DIVIDE = 3'd4,
    ST_WALK   = 3'd5,
    ST_FINISH = 3'd6
  } amc_state_e;

endpackage

[rtl/amc_isqrt.sv]
// amc_isqrt: bit-serial floor square root, two radicand bits per cycle
// depends on amc_pkg for widths

module amc_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [amc_pkg::SQ_W-1:0]   radicand_i,
  output logic [amc_pkg::MAG_W-1:0]  root_o,
  output logic                       done_o
);
  import amc_pkg::*;

  localparam int REM_W  = MAG_W + 2;
  localparam int TRY_W  = MAG_W + 4;
  localparam int CNT_W  = $clog2(MAG_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SQ_W-1:0]  rad_q, rad_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [MAG_W-1:0] root_q, root_d;

  logic [TRY_W-1:0] rem_sh;
  logic [TRY_W-1:0] trial;
  logic             fits;

  // shift in the next radicand pair, try 4*root+1
  assign rem_sh = {rem_q, rad_q[SQ_W-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d  = {rad_q[SQ_W-3:0], 2'b00};
      rem_d  = fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root_d = {root_q[MAG_W-2:0], fits};
      cnt_d  = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(MAG_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

[rtl/accel_motion_classifier_unit.sv]
// accel_motion_classifier_unit: top level of the accelerometer motion classifier
// a sample passes the square feed, root, ring update, mean divide and ring walk before
// its result beat; a shaken sample skips the mean divide and ring walk
// one sample in flight; a result left waiting stalls the next
// reset: config registers take their defaults, the ring reads as zero through per-entry
// valid bits, write slot and running sum clear; no clearing pass; needs amc_pkg, amc_isqrt

module accel_motion_classifier_unit #(
  parameter int WINDOW_DEPTH = amc_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [amc_pkg::CFG_W-1:0]     cfg_data_i,
  // sample channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [amc_pkg::AXIS_W-1:0] accel_x_i,
  input  logic signed [amc_pkg::AXIS_W-1:0] accel_y_i,
  input  logic signed [amc_pkg::AXIS_W-1:0] accel_z_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [amc_pkg::CLASS_W-1:0]   motion_class_o,
  output logic [amc_pkg::MAG_W-1:0]     magnitude_o
);
  import amc_pkg::*;

  // ring index, running sum, variance sum and threshold widths
  localparam int IDX_W = $clog2(WINDOW_DEPTH);
  localparam int NUM_W = IDX_W + 1;
  localparam int SUM_W = MAG_W + IDX_W;
  localparam int ACC_W = SQ_W + IDX_W;
  localparam int THR_W = SQ_W + 1 + NUM_W;
  localparam int DIV_CNT_W = $clog2(MAG_W);
  localparam int FEED_CNT_W = $clog2(OP_COUNT + 1);

  localparam logic [NUM_W-1:0] DEPTH_N = NUM_W'(WINDOW_DEPTH);

  function automatic logic [AXIS_W-1:0] abs_axis(input logic [AXIS_W-1:0] v);
    abs_axis = v[AXIS_W-1] ? (~v + AXIS_W'(1)) : v;
  endfunction

  function automatic logic [MAG_W-1:0] abs_diff(input logic [MAG_W-1:0] a,
                                                input logic [MAG_W-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

  // ------------------------------------------------------------------
  // configuration registers
  // ------------------------------------------------------------------
  logic [CFG_W-1:0] shake_q, carried_q, transit_q, one_g_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shake_q   <= SHAKE_RST;
      carried_q <= CARRIED_RST;
      transit_q <= TRANSIT_RST;
      one_g_q   <= ONE_G_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_SHAKE:   shake_q   <= cfg_data_i;
        REG_CARRIED: carried_q <= cfg_data_i;
        REG_TRANSIT: transit_q <= cfg_data_i;
        REG_ONE_G:   one_g_q   <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // state machine
  // ------------------------------------------------------------------
  amc_state_e state_q, state_d;

  logic in_beat;
  logic feed_issue;
  logic sq_drained;
  logic walk_issue;
  logic walk_drained;
  logic sqrt_start;
  logic ring_upd;
  logic div_step;
  logic out_load;
  logic root_done;
  logic shaken_now;

  logic [FEED_CNT_W-1:0] feed_cnt_q;
  logic                  opa_v_q, prod_v_q, rd_v_q;
  logic [NUM_W-1:0]      walk_cnt_q;
  logic [DIV_CNT_W-1:0]  div_cnt_q;
  logic                  shaken_q;
  logic                  out_valid_q;

  assign in_beat      = in_valid_i && in_ready_o;
  assign sq_drained   = (feed_cnt_q == '0) && !opa_v_q && !prod_v_q;
  assign walk_drained = (walk_cnt_q == DEPTH_N) && !rd_v_q && !opa_v_q && !prod_v_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_SQUARE;
      ST_SQUARE: if (sq_drained) state_d = ST_ROOT;
      ST_ROOT:   if (root_done) state_d = ST_UPDATE;
      ST_UPDATE: state_d = shaken_now ? ST_FINISH : ST_DIVIDE;
      ST_DIVIDE: if (div_cnt_q == DIV_CNT_W'(MAG_W - 1)) state_d = ST_WALK;
      ST_WALK:   if (walk_drained) state_d = ST_FINISH;
      ST_FINISH: if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o = 1'b0;
    feed_issue = 1'b0;
    sqrt_start = 1'b0;
    ring_upd   = 1'b0;
    div_step   = 1'b0;
    walk_issue = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_ready_o = 1'b1;
      ST_SQUARE: begin
        feed_issue = (feed_cnt_q != '0);
        sqrt_start = sq_drained;
      end
      ST_ROOT:   ;
      ST_UPDATE: ring_upd = 1'b1;
      ST_DIVIDE: div_step = 1'b1;
      ST_WALK:   walk_issue = (walk_cnt_q < DEPTH_N);
      ST_FINISH: out_load = !out_valid_q || out_ready_i;
      default:   ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ------------------------------------------------------------------
  // operand feed: |x|, |y|, |z| then the two deviation levels, one per cycle
  // ------------------------------------------------------------------
  logic [MAG_W-1:0] feed_q [OP_COUNT];
  op_tag_e          feed_tag_q [OP_COUNT];

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      feed_q[0]     <= abs_axis(accel_x_i);
      feed_q[1]     <= abs_axis(accel_y_i);
      feed_q[2]     <= abs_axis(accel_z_i);
      feed_q[3]     <= carried_q;
      feed_q[4]     <= transit_q;
      feed_tag_q[0] <= TAG_ACC;
      feed_tag_q[1] <= TAG_ACC;
      feed_tag_q[2] <= TAG_ACC;
      feed_tag_q[3] <= TAG_CSQ;
      feed_tag_q[4] <= TAG_TSQ;
    end else if (feed_issue) begin
      for (int i = 0; i < OP_COUNT - 1; i++) begin
        feed_q[i]     <= feed_q[i+1];
        feed_tag_q[i] <= feed_tag_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      feed_cnt_q <= '0;
    end else if (in_beat) begin
      feed_cnt_q <= FEED_CNT_W'(OP_COUNT);
    end else if (feed_issue) begin
      feed_cnt_q <= feed_cnt_q - FEED_CNT_W'(1);
    end
  end

  // ------------------------------------------------------------------
  // magnitude ring with per-entry valid bits
  // ------------------------------------------------------------------
  logic [MAG_W-1:0]        ring_mem [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] ring_vld_q;
  logic [IDX_W-1:0]        slot_q;
  logic [IDX_W-1:0]        rd_addr;
  logic [MAG_W-1:0]        rd_data_q;
  logic                    rd_vld_q;
  logic [MAG_W-1:0]        rd_word;
  logic [MAG_W-1:0]        mag;

  // outside the walk the read port sits on the slot about to be overwritten
  assign rd_addr = (state_q == ST_WALK) ? walk_cnt_q[IDX_W-1:0] : slot_q;
  assign rd_word = rd_vld_q ? rd_data_q : '0;

  always_ff @(posedge clk_i) begin
    rd_data_q <= ring_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ring_upd) begin
      ring_mem[slot_q] <= mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_vld_q <= '0;
      rd_vld_q   <= 1'b0;
      slot_q     <= '0;
    end else begin
      rd_vld_q <= ring_vld_q[rd_addr];
      if (ring_upd) begin
        ring_vld_q[slot_q] <= 1'b1;
        slot_q <= (slot_q == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : slot_q + IDX_W'(1);
      end
    end
  end

  // ------------------------------------------------------------------
  // shared square pipeline: operand, product, accumulate
  // ------------------------------------------------------------------
  logic [MAG_W-1:0] opa_q;
  op_tag_e          opa_tag_q, prod_tag_q;
  logic [SQ_W-1:0]  prod_q;
  logic [ACC_W-1:0] acc_q;
  logic [SQ_W-1:0]  csq_q, tsq_q;
  logic [MAG_W-1:0] mean_q;

  always_ff @(posedge clk_i) begin
    if (feed_issue) begin
      opa_q     <= feed_q[0];
      opa_tag_q <= feed_tag_q[0];
    end else begin
      // deviation of the ring entry read last cycle from the mean
      opa_q     <= abs_diff(rd_word, mean_q);
      opa_tag_q <= TAG_ACC;
    end
    prod_q     <= SQ_W'(opa_q) * SQ_W'(opa_q);
    prod_tag_q <= opa_tag_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opa_v_q  <= 1'b0;
      prod_v_q <= 1'b0;
      rd_v_q   <= 1'b0;
    end else begin
      rd_v_q   <= walk_issue;
      opa_v_q  <= feed_issue || rd_v_q;
      prod_v_q <= opa_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat || ring_upd) begin
      acc_q <= '0;
    end else if (prod_v_q) begin
      case (prod_tag_q)
        TAG_ACC: acc_q <= acc_q + ACC_W'(prod_q);
        TAG_CSQ: csq_q <= prod_q;
        TAG_TSQ: tsq_q <= prod_q;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // magnitude root
  // ------------------------------------------------------------------
  amc_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (acc_q[SQ_W-1:0]),
    .root_o     (mag),
    .done_o     (root_done)
  );

  // ------------------------------------------------------------------
  // ring update, shake test, running sum and thresholds
  // ------------------------------------------------------------------
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [THR_W-1:0] cthr_q, tthr_q;

  assign shaken_now = (abs_diff(mag, one_g_q) > shake_q);
  // old entry leaves the running sum, new magnitude joins it
  assign sum_d      = (sum_q - SUM_W'(rd_word)) + SUM_W'(mag);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      shaken_q <= 1'b0;
    end else if (ring_upd) begin
      sum_q    <= sum_d;
      shaken_q <= shaken_now;
    end
  end

  // floor(s/n) > c*c exactly when s >= n*(c*c + 1)
  always_ff @(posedge clk_i) begin
    if (ring_upd) begin
      cthr_q <= (THR_W'(csq_q) + THR_W'(1)) * THR_W'(WINDOW_DEPTH);
      tthr_q <= (THR_W'(tsq_q) + THR_W'(1)) * THR_W'(WINDOW_DEPTH);
    end
  end

  // ------------------------------------------------------------------
  // mean: restoring division by the window depth, one quotient bit a cycle
  // ------------------------------------------------------------------
  logic [IDX_W-1:0] drem_q;
  logic [NUM_W-1:0] drem_sh;
  logic             dbit;

  assign drem_sh = {drem_q, mean_q[MAG_W-1]};
  assign dbit    = (drem_sh >= DEPTH_N);

  always_ff @(posedge clk_i) begin
    if (ring_upd) begin
      // the upper part of the sum is always below the depth
      drem_q <= sum_d[SUM_W-1:MAG_W];
      mean_q <= sum_d[MAG_W-1:0];
    end else if (div_step) begin
      drem_q <= dbit ? IDX_W'(drem_sh - DEPTH_N) : IDX_W'(drem_sh);
      mean_q <= {mean_q[MAG_W-2:0], dbit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q  <= '0;
      walk_cnt_q <= '0;
    end else begin
      if (ring_upd) begin
        div_cnt_q <= '0;
      end else if (div_step) begin
        div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
      end
      if (div_step) begin
        walk_cnt_q <= '0;
      end else if (walk_issue) begin
        walk_cnt_q <= walk_cnt_q + NUM_W'(1);
      end
    end
  end

  // ------------------------------------------------------------------
  // result register, frees the core while a beat waits downstream
  // ------------------------------------------------------------------
  motion_class_e    class_sel;
  logic [THR_W-1:0] var_sum;
  logic [CLASS_W-1:0] class_q;
  logic [MAG_W-1:0]   mag_out_q;

  assign var_sum = THR_W'(acc_q);

  always_comb begin
    if (shaken_q) begin
      class_sel = CLASS_SHAKEN;
    end else if (var_sum >= cthr_q) begin
      class_sel = CLASS_CARRIED;
    end else if (var_sum >= tthr_q) begin
      class_sel = CLASS_TRANSIT;
    end else begin
      class_sel = CLASS_STATIONARY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      class_q   <= class_sel;
      mag_out_q <= mag;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign motion_class_o = class_q;
  assign magnitude_o    = mag_out_q;

`ifndef SYNTH
  a_slot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(slot_q) < WINDOW_DEPTH)
    else $error("write slot beyond the window");

  a_beat_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> (state_q == ST_SQUARE))
    else $error("accepted beat did not start the square phase");

  a_root_done_in_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_done |-> (state_q == ST_ROOT))
    else $error("root finished outside the root phase");

  a_prod_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prod_v_q |-> (state_q == ST_SQUARE || state_q == ST_WALK))
    else $error("square pipeline busy outside square or walk phase");

  a_mag_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (mag <= MAG_MAX))
    else $error("magnitude above the largest possible root");
`endif

endmodule

[bench/tb_accel_motion_classifier_unit.sv]
// tb_accel_motion_classifier_unit: self-checking bench for the motion classifier,
// predicting magnitude and activity class per sample and scoring every result beat
// depends on amc_pkg and accel_motion_classifier_unit

module tb_accel_motion_classifier_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import amc_pkg::*;

  localparam int RING_DEPTH     = WINDOW_DEPTH_DEF;
  // worst case is the full ring walk, plus some slack for the hand-back to idle
  localparam int RESULT_LATENCY = 64 + 16;

  typedef struct packed {
    motion_class_e           cls;
    logic [MAG_W-1:0]        mag;
  } motion_result_t;

  // ---------------------------------------------------------------------------
  // scoreboard: a private copy of the thresholds and magnitude ring, so each
  // accepted sample can be turned into its expected class and magnitude
  // ---------------------------------------------------------------------------
  class motion_scoreboard;
    logic [CFG_W-1:0]  shake_lim;
    logic [CFG_W-1:0]  carried_dev;
    logic [CFG_W-1:0]  transit_dev;
    logic [CFG_W-1:0]  one_g;
    logic [MAG_W-1:0]  ring [RING_DEPTH];
    int unsigned       slot;
    motion_result_t    expected_q [$];
    int unsigned       mismatches;
    int unsigned       checked;
    int unsigned       class_seen [4];

    function new();
      shake_lim   = SHAKE_RST;
      carried_dev = CARRIED_RST;
      transit_dev = TRANSIT_RST;
      one_g       = ONE_G_RST;
      foreach (ring[i]) ring[i] = '0;
      slot        = 0;
      mismatches  = 0;
      checked     = 0;
      foreach (class_seen[i]) class_seen[i] = 0;
    endfunction

    // exact floor square root, digit by digit
    static function longint floor_root(input longint n);
      longint rest;
      longint root;
      longint probe;
      rest  = n;
      root  = 0;
      probe = longint'(1) << 40;
      while (probe > rest) probe = probe >> 2;
      while (probe != 0) begin
        if (rest >= root + probe) begin
          rest = rest - (root + probe);
          root = (root >> 1) + probe;
        end else begin
          root = root >> 1;
        end
        probe = probe >> 2;
      end
      return root;
    endfunction

    function void set_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
      case (idx)
        REG_SHAKE:   shake_lim   = val;
        REG_CARRIED: carried_dev = val;
        REG_TRANSIT: transit_dev = val;
        REG_ONE_G:   one_g       = val;
        default: ;
      endcase
    endfunction

    function int unsigned pending_count();
      return expected_q.size();
    endfunction

    // accepted sample beat: update the ring and queue the expected result
    function void note_sample(input logic signed [AXIS_W-1:0] ax, ay, az);
      longint           energy;
      longint           deviation;
      longint           total;
      longint           mean;
      longint           variance;
      longint           d;
      logic [MAG_W-1:0] mag;
      motion_class_e    cls;
      motion_result_t   res;
      energy = longint'(ax) * longint'(ax) + longint'(ay) * longint'(ay)
             + longint'(az) * longint'(az);
      mag = MAG_W'(floor_root(energy));
      // the sample enters the ring whether or not it turns out shaken
      ring[slot] = mag;
      slot = (slot + 1) % RING_DEPTH;
      deviation = longint'(mag) - longint'(one_g);
      if (deviation < 0) deviation = -deviation;
      if (deviation > longint'(shake_lim)) begin
        cls = CLASS_SHAKEN;
      end else begin
        total = 0;
        foreach (ring[i]) total += longint'(ring[i]);
        mean = total / RING_DEPTH;
        variance = 0;
        foreach (ring[i]) begin
          d = longint'(ring[i]) - mean;
          variance += d * d;
        end
        variance = variance / RING_DEPTH;
        // strictly above the squared level, so a tie falls to the lower class
        if (variance > longint'(carried_dev) * longint'(carried_dev)) begin
          cls = CLASS_CARRIED;
        end else if (variance > longint'(transit_dev) * longint'(transit_dev)) begin
          cls = CLASS_TRANSIT;
        end else begin
          cls = CLASS_STATIONARY;
        end
      end
      res.cls = cls;
      res.mag = mag;
      expected_q.push_back(res);
    endfunction

    task log_mismatch(input string what);
      mismatches++;
      $display("MISMATCH @%0t: %s", $time, what);
    endtask

    // accepted result beat: compare with the oldest expectation
    task check_result(input logic [CLASS_W-1:0] got_cls, input logic [MAG_W-1:0] got_mag);
      motion_result_t want;
      if (expected_q.size() == 0) begin
        log_mismatch($sformatf("result beat with nothing pending: class %0d magnitude %0d",
                               got_cls, got_mag));
        return;
      end
      want = expected_q.pop_front();
      checked++;
      class_seen[want.cls]++;
      if (got_cls != want.cls)
        log_mismatch($sformatf("result %0d: class %0d, expected %0d",
                               checked, got_cls, want.cls));
      if (got_mag != want.mag)
        log_mismatch($sformatf("result %0d: magnitude %0d, expected %0d",
                               checked, got_mag, want.mag));
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // clock, reset and block signals; those the bench drives are known from time zero
  // ---------------------------------------------------------------------------
  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      cfg_we_i    = 1'b0;
  logic [1:0]                cfg_index_i = REG_SHAKE;
  logic [CFG_W-1:0]          cfg_data_i  = '0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_ready_o;
  logic signed [AXIS_W-1:0]  accel_x_i   = '0;
  logic signed [AXIS_W-1:0]  accel_y_i   = '0;
  logic signed [AXIS_W-1:0]  accel_z_i   = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [CLASS_W-1:0]        motion_class_o;
  logic [MAG_W-1:0]          magnitude_o;

  motion_scoreboard sb = new();

  // when set, neither side idles: a long back-to-back stretch
  bit          calm             = 1'b0;
  int unsigned samples_sent     = 0;
  int unsigned settings_applied = 0;

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  accel_motion_classifier_unit #(
    .WINDOW_DEPTH (RING_DEPTH)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .accel_x_i      (accel_x_i),
    .accel_y_i      (accel_y_i),
    .accel_z_i      (accel_z_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .motion_class_o (motion_class_o),
    .magnitude_o    (magnitude_o)
  );

  // each call takes a break with a 23 percent chance, unless in the calm stretch
  function automatic bit take_break();
    return !calm && ($urandom_range(0, 99) < 23);
  endfunction

  // ---------------------------------------------------------------------------
  // driving tasks
  // ---------------------------------------------------------------------------

  // one sample beat; valid is only lowered when a gap is actually taken, so a
  // back-to-back beat never sees valid dropped and raised in the same step
  task automatic send_sample(input logic signed [AXIS_W-1:0] sx, sy, sz);
    if (take_break()) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (take_break());
    end
    in_valid_i <= 1'b1;
    accel_x_i  <= sx;
    accel_y_i  <= sy;
    accel_z_i  <= sz;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(sx, sy, sz);
    samples_sent++;
  endtask

  // stop offering samples and wait for every expected result beat
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk_i);
  endtask

  // write all four thresholds back to back, with the write enable held high
  task automatic apply_settings(input logic [CFG_W-1:0] shake, carried, transit, oneg);
    logic [CFG_W-1:0] vals [4];
    cfg_reg_e         idx;
    vals = '{shake, carried, transit, oneg};
    idx  = REG_SHAKE;
    repeat (4) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= vals[idx];
      @(posedge clk_i);
      sb.set_reg(idx, vals[idx]);
      idx = idx.next();
    end
    cfg_we_i <= 1'b0;
    settings_applied++;
  endtask

  // a vector whose magnitude is close to target: either all on one axis or
  // spread over three axes, random signs and axis order
  function automatic void shape_sample(input int target,
                                       output logic signed [AXIS_W-1:0] sx, sy, sz);
    int m;
    int a;
    int b;
    int c;
    m = target;
    if (m < 0) m = 0;
    if (m > 32767) m = 32767;
    if ($urandom_range(0, 1) == 0) begin
      a = 0;
      b = 0;
      c = m;
    end else begin
      a = int'($urandom_range(0, m / 2));
      b = int'($urandom_range(0, m / 2));
      c = int'(motion_scoreboard::floor_root(longint'(m) * m - longint'(a) * a
                                               - longint'(b) * b));
    end
    if ($urandom_range(0, 1) == 1) a = -a;
    if ($urandom_range(0, 1) == 1) b = -b;
    if ($urandom_range(0, 1) == 1) c = -c;
    case ($urandom_range(0, 2))
      0: begin sx = 16'(a); sy = 16'(b); sz = 16'(c); end
      1: begin sx = 16'(c); sy = 16'(a); sz = 16'(b); end
      default: begin sx = 16'(b); sy = 16'(c); sz = 16'(a); end
    endcase
  endfunction

  // one register setting followed by bursts of samples: mostly steady runs
  // around a level near one g with a chosen jitter, some wild magnitudes and
  // some raw noise on all bits
  task automatic run_phase(input logic [CFG_W-1:0] shake, carried, transit, oneg,
                           input int count);
    int                       sent;
    int                       len;
    int                       style;
    int                       span;
    int                       center;
    int                       spread;
    int                       target;
    logic signed [AXIS_W-1:0] sx;
    logic signed [AXIS_W-1:0] sy;
    logic signed [AXIS_W-1:0] sz;
    settle_block();
    apply_settings(shake, carried, transit, oneg);
    sent = 0;
    while (sent < count) begin
      len   = int'($urandom_range(4, 24));
      style = int'($urandom_range(0, 99));
      span  = int'(shake) + int'(shake) / 4 + 1;
      if (span > 20000) span = 20000;
      center = int'(oneg) + int'($urandom_range(0, 2 * span)) - span;
      case ($urandom_range(0, 4))
        0:       spread = 0;
        1:       spread = 40;
        2:       spread = 250;
        3:       spread = 600;
        default: spread = 1500;
      endcase
      repeat (len) begin
        if (style < 70) begin
          target = center + int'($urandom_range(0, 2 * spread)) - spread;
          shape_sample(target, sx, sy, sz);
        end else if (style < 85) begin
          shape_sample(int'($urandom_range(0, 32767)), sx, sy, sz);
        end else begin
          sx = 16'($urandom);
          sy = 16'($urandom);
          sz = 16'($urandom);
        end
        send_sample(sx, sy, sz);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: ready stalls at random, every accepted beat is scored
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_result(motion_class_o, magnitude_o);
      out_ready_i <= !take_break();
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part under reset thresholds; the ring still holds its zeros
    send_sample(16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000);    // largest magnitude
    send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_sample(16'sh8000, 16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sh7FFF, 16'sd0);
    send_sample(16'sd0, 16'sd0, 16'sh8000);
    // one g plus and minus the shake limit: on the limit is not shaken
    send_sample(16'sd0, 16'sd0, 16'sd18884);
    send_sample(16'sd0, 16'sd0, 16'sd18885);
    send_sample(16'sd0, -16'sd13884, 16'sd0);
    send_sample(-16'sd13883, 16'sd0, 16'sd0);
    send_sample(16'sd12000, -16'sd9000, 16'sd7000);
    // settle at rest so the zero entries wash out of the ring
    for (int n = 0; n < 14; n++) begin
      case (n % 3)
        0:       send_sample(16'sd0, 16'sd0, 16'sd16384);
        1:       send_sample(-16'sd16384, 16'sd0, 16'sd0);
        default: send_sample(16'sd0, 16'sd16384, 16'sd0);
      endcase
    end

    // reset values written back explicitly
    run_phase(SHAKE_RST, CARRIED_RST, TRANSIT_RST, ONE_G_RST, 250);
    // never shaken, any spread at all reads as carried, a flat ring ties at zero
    run_phase(16'hFFFF, 16'd0, 16'd0, 16'd0, 100);
    // no shake margin and one g out of reach: every sample shaken
    run_phase(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 50);
    // long stretch with no idling on either side
    calm = 1'b1;
    run_phase(16'($urandom_range(500, 4000)), 16'($urandom_range(300, 1500)),
              16'($urandom_range(50, 300)), 16'($urandom_range(8000, 24000)), 130);
    calm = 1'b0;
    run_phase(16'($urandom_range(500, 4000)), 16'($urandom_range(300, 1500)),
              16'($urandom_range(50, 300)), 16'($urandom_range(8000, 24000)), 130);
    // very tight limits around one g
    run_phase(16'd1, 16'd30, 16'd5, ONE_G_RST, 100);
    // everything at the top except one g at zero: only stationary possible
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 60);

    settle_block();
    repeat (RESULT_LATENCY) @(posedge clk_i);

    $display("run covered %0d samples under %0d threshold settings, %0d results scored",
             samples_sent, settings_applied, sb.checked);
    $display("classes seen: stationary %0d, transit %0d, carried %0d, shaken %0d",
             sb.class_seen[CLASS_STATIONARY], sb.class_seen[CLASS_TRANSIT],
             sb.class_seen[CLASS_CARRIED], sb.class_seen[CLASS_SHAKEN]);
    if (sb.mismatches == 0) begin
      $display("tb_accel_motion_classifier_unit: clean");
    end else begin
      $display("tb_accel_motion_classifier_unit: errors");
    end
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin : watchdog
    #10ms;
    $display("tb_accel_motion_classifier_unit: errors");
    $finish;
  end

endmodule
